>>> rtl/cqs_pkg.sv
// Package for the circular queue with search: sizes, opcodes, status codes,
// controller state type and the probe word handed along the cell chain.
// No dependencies.
package cqs_pkg;

  // Ring sizes, fixed by the 3-bit slot and 4-bit capacity fields
  localparam int DEPTH  = 8;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 4;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map, as word index paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // Operation codes
  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_DEQ    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;
  localparam logic [1:0] STS_MISS  = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // Search probe passed from one cell to the next
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] remain;
  } probe_t;

endpackage

>>> rtl/circular_queue_with_search.sv
// Top level of the circular queue with search: register port, controller,
// head/tail/occupancy and the ring of slot cells. Depends on cqs_pkg, cqs_cell.
//
// Usage: each input word carries op (enqueue, dequeue, search) and value.
// A word is taken when in_valid is high and in_stall is low; every word
// yields exactly one result word (status, slot, data_out) on the output
// channel, taken when out_valid is high and out_stall is low.
// Enqueue and dequeue: the result goes through the result register into the
// output register, and the next word is taken once it is loaded there. A
// search sends a probe around the ring of cells, one slot per cycle from head
// toward tail, to the entry that matches the key or, on a miss, past all
// occupied entries; this walk along the cell chain sets how long a search
// takes, and its result then goes on to the output register in the same way.
// While the receiver stalls, a finished result waits in the result register
// and the input stays stalled until the output register is free. Capacity
// sits at byte address 0 of the APB port and a write to it empties the
// queue; write it only while the block is idle. Reset (synchronous) empties
// the queue and sets capacity to 8; stored words are undefined until an
// enqueue writes them.
module circular_queue_with_search (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cqs_pkg::ADDR_W-1:0]    paddr,
  input  logic [cqs_pkg::PDATA_W-1:0]   pwdata,
  output logic [cqs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic signed [cqs_pkg::DATA_W-1:0] value,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [cqs_pkg::IDX_W-1:0]     slot,
  output logic signed [cqs_pkg::DATA_W-1:0] data_out
);
  import cqs_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]  capacity;
  logic [IDX_W-1:0]  head, tail;
  logic [CNT_W-1:0]  occ;
  logic [DATA_W-1:0] key;
  logic [1:0]        res_status;
  logic [IDX_W-1:0]  res_slot;
  logic [DATA_W-1:0] res_data;
  logic [1:0]        res_status_next;
  logic [IDX_W-1:0]  res_slot_next;
  logic [DATA_W-1:0] res_data_next;

  logic [IDX_W-1:0]  capm1;
  logic              cfg_wr;
  logic              accept;
  logic              is_full, is_empty;
  logic              start_search;
  logic              out_load;
  logic [IDX_W-1:0]  head_adv, tail_adv;

  probe_t            probe_in  [DEPTH];
  probe_t            probe_out [DEPTH];
  logic [DEPTH-1:0]  hit_vec;
  logic [DEPTH-1:0]  active_vec;
  logic [DATA_W-1:0] words     [DEPTH];
  logic              any_hit, any_probe;
  logic [IDX_W-1:0]  hit_slot;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  // Effective capacity minus one: zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    if (capacity == '0) begin
      capm1 = '0;
    end else if (capacity > CNT_W'(DEPTH)) begin
      capm1 = IDX_W'(DEPTH - 1);
    end else begin
      capm1 = IDX_W'(capacity - CNT_W'(1));
    end
  end

  assign is_full  = occ > {1'b0, capm1};
  assign is_empty = (occ == '0);
  assign head_adv = (head == capm1) ? '0 : head + IDX_W'(1);
  assign tail_adv = (tail == capm1) ? '0 : tail + IDX_W'(1);

  assign accept       = in_valid && !in_stall;
  assign start_search = accept && (op == OP_SEARCH) && !is_empty;

  // Ring of slot cells; a probe wraps from the last used cell back to cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign probe_in[i] = probe_out[capm1];
    end else begin : g_rest
      assign probe_in[i] = (capm1 == IDX_W'(i - 1)) ? '0 : probe_out[i-1];
    end

    cqs_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .wr_en        (accept && (op == OP_ENQ) && !is_full && (tail == IDX_W'(i))),
      .wr_data      (value),
      .start        (start_search && (head == IDX_W'(i))),
      .start_remain (occ),
      .key          (key),
      .probe_in     (probe_in[i]),
      .probe_out    (probe_out[i]),
      .hit          (hit_vec[i]),
      .active       (active_vec[i]),
      .word         (words[i])
    );
  end

  // Encode the hit position; at most one probe is in the ring
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) begin
        hit_slot = hit_slot | IDX_W'(i);
      end
    end
  end
  assign any_hit   = |hit_vec;
  assign any_probe = |active_vec;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ((op == OP_SEARCH) && !is_empty) ? ST_SEARCH : ST_DONE;
        end
      end
      ST_SEARCH: begin
        if (any_hit || !any_probe) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_SEARCH: in_stall = 1'b1;
      ST_DONE:   out_load = !out_valid || !out_stall;
      default:   in_stall = 1'b1;
    endcase
  end

  // Control state, queue pointers and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= CNT_W'(DEPTH);
      head     <= '0;
      tail     <= '0;
      occ      <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        capacity <= pwdata[CNT_W-1:0];
        head     <= '0;
        tail     <= '0;
        occ      <= '0;
      end else if (accept) begin
        if ((op == OP_ENQ) && !is_full) begin
          tail <= tail_adv;
          occ  <= occ + CNT_W'(1);
        end else if ((op == OP_DEQ) && !is_empty) begin
          head <= head_adv;
          occ  <= occ - CNT_W'(1);
        end
      end
    end
  end

  // Build the next result word
  always_comb begin
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_data_next   = res_data;
    if (accept) begin
      res_status_next = STS_OK;
      res_slot_next   = '0;
      res_data_next   = '0;
      case (op)
        OP_ENQ: begin
          if (is_full) begin
            res_status_next = STS_FULL;
          end
        end
        OP_DEQ: begin
          if (is_empty) begin
            res_status_next = STS_EMPTY;
          end else begin
            res_data_next = words[head];
          end
        end
        OP_SEARCH: begin
          if (is_empty) begin
            res_status_next = STS_EMPTY;
          end
        end
        default: res_status_next = STS_OK;
      endcase
    end else if (state == ST_SEARCH) begin
      if (any_hit) begin
        res_status_next = STS_OK;
        res_slot_next   = hit_slot;
      end else if (!any_probe) begin
        res_status_next = STS_MISS;
      end
    end
  end

  // Hold the search key and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= value;
    end
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_data   <= res_data_next;
  end

  // Output register: hold while stalled, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status   <= res_status;
      slot     <= res_slot;
      data_out <= res_data;
    end
  end

endmodule

>>> rtl/cqs_cell.sv
// One ring slot: holds a stored word and the search probe while it visits.
// Compares the search key with its word and forwards a missed probe.
// Depends on cqs_pkg.
module cqs_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [cqs_pkg::DATA_W-1:0]    wr_data,
  input  logic                          start,
  input  logic [cqs_pkg::CNT_W-1:0]     start_remain,
  input  logic [cqs_pkg::DATA_W-1:0]    key,
  input  cqs_pkg::probe_t               probe_in,
  output cqs_pkg::probe_t               probe_out,
  output logic                          hit,
  output logic                          active,
  output logic [cqs_pkg::DATA_W-1:0]    word
);
  import cqs_pkg::*;

  probe_t probe;

  // Store the word on enqueue
  always_ff @(posedge clk) begin
    if (wr_en) begin
      word <= wr_data;
    end
  end

  // Load the probe at search start, else take it from the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      probe <= '0;
    end else if (start) begin
      probe.valid  <= 1'b1;
      probe.remain <= start_remain;
    end else begin
      probe <= probe_in;
    end
  end

  // Compare and forward a miss while entries remain
  always_comb begin
    active           = probe.valid;
    hit              = probe.valid && (word == key);
    probe_out.valid  = probe.valid && !hit && (probe.remain > CNT_W'(1));
    probe_out.remain = probe.remain - CNT_W'(1);
  end

endmodule

>>> bench/circular_queue_with_search_tb.sv
// Testbench for circular_queue_with_search: a stimulus table, then random op words
// under several capacity settings, each result word checked against a queue predictor.
// Depends on cqs_pkg and the circular_queue_with_search RTL.
module circular_queue_with_search_tb;
  import cqs_pkg::*;

  // op code that the block leaves unused
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 85;
  localparam int SETTLE_CYCLES = 16;
  localparam int STUCK_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] data;
  } reply_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] value;
    logic              typed;
    reply_t            reply;
  } script_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [1:0] op;
  logic signed [DATA_W-1:0] value;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic [IDX_W-1:0] slot;
  logic signed [DATA_W-1:0] data_out;

  // predictor copy of the queue
  logic [DATA_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]  q_head, q_tail;
  logic [CNT_W-1:0]  q_fill;
  logic [CNT_W-1:0]  cap_reg;

  reply_t reply_q [$];
  int fault_count;
  int stuck_cycles;
  bit idle_on;

  // fixed opening sequence at reset capacity; typed rows carry their own answer
  script_row_t script_rows [0:20] = '{
    '{OP_DEQ,    32'h0000_0000, 1'b1, '{STS_EMPTY, 3'd0, 32'h0}},
    '{OP_SEARCH, 32'h0000_0001, 1'b1, '{STS_EMPTY, 3'd0, 32'h0}},
    '{OP_NONE,   32'hFFFF_FFFF, 1'b1, '{STS_OK, 3'd0, 32'h0}},
    '{OP_ENQ,    32'h7FFF_FFFF, 1'b1, '{STS_OK, 3'd0, 32'h0}},
    '{OP_ENQ,    32'h8000_0000, 1'b1, '{STS_OK, 3'd0, 32'h0}},
    '{OP_ENQ,    32'h0000_0000, 1'b1, '{STS_OK, 3'd0, 32'h0}},
    '{OP_ENQ,    32'hFFFF_FFFF, 1'b1, '{STS_OK, 3'd0, 32'h0}},
    '{OP_SEARCH, 32'hFFFF_FFFF, 1'b1, '{STS_OK, 3'd3, 32'h0}},
    '{OP_SEARCH, 32'h8000_0000, 1'b1, '{STS_OK, 3'd1, 32'h0}},
    '{OP_SEARCH, 32'h0000_0000, 1'b0, '0},
    '{OP_SEARCH, 32'h1234_5678, 1'b1, '{STS_MISS, 3'd0, 32'h0}},
    '{OP_ENQ,    32'h8000_0000, 1'b0, '0},
    '{OP_ENQ,    32'h5555_5555, 1'b0, '0},
    '{OP_ENQ,    32'hAAAA_AAAA, 1'b0, '0},
    '{OP_ENQ,    32'h0000_0001, 1'b0, '0},
    '{OP_ENQ,    32'h0000_0002, 1'b1, '{STS_FULL, 3'd0, 32'h0}},
    '{OP_DEQ,    32'h0000_0000, 1'b1, '{STS_OK, 3'd0, 32'h7FFF_FFFF}},
    '{OP_ENQ,    32'h0000_0009, 1'b0, '0},
    '{OP_SEARCH, 32'h0000_0009, 1'b1, '{STS_OK, 3'd0, 32'h0}},
    '{OP_SEARCH, 32'h8000_0000, 1'b0, '0},
    '{OP_DEQ,    32'h0000_0000, 1'b1, '{STS_OK, 3'd0, 32'h8000_0000}}
  };

  circular_queue_with_search DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .slot(slot), .data_out(data_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // effective wrap point: zero acts as one, anything above DEPTH as DEPTH
  function automatic int wrap_point();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] idx);
    int n;
    n = int'(idx) + 1;
    return (n >= wrap_point()) ? '0 : IDX_W'(n);
  endfunction

  // apply one op word to the predictor queue and return its result word
  function automatic reply_t queue_reply(logic [1:0] code, logic [DATA_W-1:0] key);
    reply_t r;
    logic [IDX_W-1:0] pos;
    bit hit;
    int k;
    r = '0;
    case (code)
      OP_ENQ: begin
        if (q_fill >= wrap_point()) begin
          r.status = STS_FULL;
        end else begin
          ring_words[q_tail] = key;
          q_tail = next_slot(q_tail);
          q_fill = q_fill + 1'b1;
        end
      end
      OP_DEQ: begin
        if (q_fill == 0) begin
          r.status = STS_EMPTY;
        end else begin
          r.data = ring_words[q_head];
          q_head = next_slot(q_head);
          q_fill = q_fill - 1'b1;
        end
      end
      OP_SEARCH: begin
        if (q_fill == 0) begin
          r.status = STS_EMPTY;
        end else begin
          pos = q_head;
          hit = 1'b0;
          for (k = 0; k < int'(q_fill); k++) begin
            if (!hit && ring_words[pos] == key) begin
              hit = 1'b1;
              r.slot = pos;
            end
            pos = next_slot(pos);
          end
          if (!hit) r.status = STS_MISS;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one op word, hold it until taken, then queue its expected result
  task automatic send_word(input logic [1:0] code, input logic [DATA_W-1:0] word,
                           input logic typed, input reply_t typed_reply);
    reply_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = queue_reply(code, word);
    if (typed) want = typed_reply;
    reply_q.push_back(want);
  endtask

  // stop offering words and wait until every result word is back
  task automatic settle_queue();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] word);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    // a capacity write also empties the queue; stored words stay
    if (addr == CAPACITY_ADDR) begin
      cap_reg = word[CNT_W-1:0];
      q_head = '0;
      q_tail = '0;
      q_fill = '0;
    end
  endtask

  task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [PDATA_W-1:0] word);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    word = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write capacity and read it back
  task automatic set_capacity(input logic [PDATA_W-1:0] word);
    logic [PDATA_W-1:0] back;
    apb_write(CAPACITY_ADDR, word);
    @(posedge clk);
    apb_read(CAPACITY_ADDR, back);
    if (back !== PDATA_W'(word[CNT_W-1:0])) begin
      $display("%0t: capacity readback mismatch, expected %0d, got %0d",
               $time, word[CNT_W-1:0], back);
      fault_count++;
    end
  endtask

  // receiver stalls in random bursts while idle_on is set
  initial begin
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (idle_on) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // check each result word against the oldest expectation; watch for a hang
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (reply_q.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, got %0d/%0d/%h",
                 $time, status, slot, data_out);
        fault_count++;
      end else begin
        want = reply_q.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
          fault_count++;
        end
        if (slot !== want.slot) begin
          $display("%0t: slot mismatch, expected %0d, got %0d", $time, want.slot, slot);
          fault_count++;
        end
        if (data_out !== want.data) begin
          $display("%0t: data_out mismatch, expected %h, got %h", $time, want.data, data_out);
          fault_count++;
        end
      end
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: timeout, %0d result words outstanding", $time, reply_q.size());
      $display("** circular_queue_with_search: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] key_pool [6];
    logic [PDATA_W-1:0] cap_word;
    logic [1:0] code;
    logic [DATA_W-1:0] word;
    int enq_pct;
    int pick;
    int ph;
    int n;
    int i;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    op <= OP_ENQ;
    value <= '0;
    fault_count = 0;
    stuck_cycles = 0;
    idle_on = 1'b1;
    cap_reg = CNT_W'(DEPTH);
    q_head = '0;
    q_tail = '0;
    q_fill = '0;
    enq_pct = 50;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the stimulus table
    for (i = 0; i < 21; i++)
      send_word(script_rows[i].op, script_rows[i].value, script_rows[i].typed,
                script_rows[i].reply);

    // random phases, each under its own capacity; the last one without idling
    for (ph = 0; ph < PHASES; ph++) begin
      settle_queue();
      case (ph)
        0: cap_word = 32'd1;
        1: cap_word = 32'd0;
        2: cap_word = 32'hFFFF_FFF2;
        3: cap_word = 32'd15;
        4: cap_word = 32'd3;
        5: cap_word = $urandom;
        6: cap_word = 32'd8;
        default: cap_word = 32'd5;
      endcase
      set_capacity(cap_word);
      if (ph == PHASES - 1) idle_on = 1'b0;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      for (i = 2; i < 6; i++) key_pool[i] = $urandom;

      for (n = 0; n < PHASE_WORDS; n++) begin
        // write to an address past the register list: must leave the queue alone
        if (ph == 2 && n == PHASE_WORDS / 2) begin
          settle_queue();
          apb_write(SPARE_ADDR, $urandom);
        end
        // swing between filling and draining
        if (n % 16 == 0) enq_pct = $urandom_range(25, 70);
        pick = $urandom_range(0, 99);
        if (pick < 4) code = OP_NONE;
        else if (pick < 4 + enq_pct) code = OP_ENQ;
        else if (pick < 4 + enq_pct + (96 - enq_pct) / 2) code = OP_DEQ;
        else code = OP_SEARCH;
        if ($urandom_range(0, 1) == 0) word = key_pool[$urandom_range(0, 5)];
        else word = $urandom;
        send_word(code, word, 1'b0, '0);
      end
    end

    settle_queue();
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("** circular_queue_with_search: PASSED **");
    end else begin
      $display("** circular_queue_with_search: FAILED **");
    end
    $finish;
  end

endmodule

>>> circular_queue_with_search.f
rtl/cqs_pkg.sv
rtl/cqs_cell.sv
rtl/circular_queue_with_search.sv
bench/circular_queue_with_search_tb.sv
